### hw/rtl/rsb_pkg.sv
// ----------------------------------------------------------------------------
// rsb_pkg: shared constants and channel math for the RGB555 saturation boost
// Channel layout, the divide-by-three reciprocal and the per-channel
// boost and soft-clip functions used by the pipeline stages.
// ----------------------------------------------------------------------------
package rsb_pkg;

   localparam int ChanW   = 5;
   localparam int ColorW  = 16;
   localparam int SumW    = 7;   // r+g+b, 0..93
   localparam int VW      = 8;   // boosted channel value, -41..81

   localparam logic [ChanW-1:0] ChanMax = 5'h1F;

   // floor(sum/3) == (sum*43) >> 7 for every sum below 128
   localparam logic [5:0] GrayMul   = 6'd43;
   localparam int         GrayShift = 7;

   localparam logic signed [12:0] BoostMul = 13'sd21;

   localparam logic signed [VW-1:0] KneeLo  = 8'sd22;
   localparam logic signed [VW-1:0] KneeHi  = 8'sd30;
   localparam logic signed [VW-1:0] KneeMid = 8'sd26;
   localparam logic signed [VW-1:0] ClipCap = 8'sd30;

   typedef logic [ChanW-1:0] chan_type;

   function automatic chan_type gray_of(input logic [SumW-1:0] sum);
      logic [12:0] prod;
      prod = 13'(sum) * 13'(GrayMul);
      return prod[GrayShift +: ChanW];
   endfunction

   // (2*ch - gray) * 21, arithmetic shift right by 4
   function automatic logic signed [VW-1:0] boost_v(input chan_type ch,
                                                    input chan_type gray);
      logic signed [VW-1:0] s;
      logic signed [12:0]   p;
      s = $signed({2'b00, ch, 1'b0}) - $signed({3'b000, gray});
      p = 13'(s) * BoostMul;
      return VW'(p >>> 4);
   endfunction

   function automatic chan_type clip(input logic signed [VW-1:0] v,
                                     input chan_type orig);
      logic signed [VW-1:0] d;
      logic signed [VW-1:0] t;
      chan_type             r;
      d = '0;
      t = '0;
      priority if (orig == ChanMax) begin
         r = ChanMax;
      end else if (v < 0) begin
         r = '0;
      end else if (v <= KneeLo) begin
         r = v[ChanW-1:0];
      end else if (v <= KneeHi) begin
         d = v - KneeLo;
         t = KneeLo + (d >>> 1);
         r = t[ChanW-1:0];
      end else begin
         d = v - KneeHi;
         t = KneeMid + (d >>> 2);
         r = (t > ClipCap) ? ClipCap[ChanW-1:0] : t[ChanW-1:0];
      end
      return r;
   endfunction

endpackage

### hw/rtl/rgb555_saturation_boost.sv
// ----------------------------------------------------------------------------
// rgb555_saturation_boost: four-stage saturation boost for RGB555 colors
// Gray estimate, per-channel boost and soft clip on a stream of color words.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one color word per transfer (tdata: color_in, bits 15:0;
//   red 4:0, green 9:5, blue 14:10, bit 15 spare). rsp_* returns one
//   processed word per input word in order (tdata: color_out, bits 15:0).
//   csr_* writes boost_enable (csr_data bit 0); csr_ready is always high.
//   Write it only while no words are in flight.
//   With boost_enable clear a word passes through unchanged; with it set
//   each channel is pushed away from gray, soft clipped and bit 15 cleared.
//   A word goes from a req transfer to rsp_tvalid through the four register
//   stages (sum, gray, boost, clip) in order. Throughput: one word per cycle
//   while rsp_tready is high; each stage takes a new word when it advances.
//   When the receiver stalls, the stages fill up one by one; req_tready
//   drops only when all four hold a word. Nothing is lost or repeated.
//   Reset empties the pipeline and clears boost_enable.
// ----------------------------------------------------------------------------
module rgb555_saturation_boost (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // color_in [15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // color_out [15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // boost_enable
);

   localparam int CW = rsb_pkg::ChanW;

   logic boost_enable_ff;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv1, adv2, adv3, adv4;

   logic [rsb_pkg::ColorW-1:0] color1_ff, color2_ff, color3_ff;
   logic [rsb_pkg::ColorW-1:0] out_ff;
   logic                       en1_ff, en2_ff, en3_ff, en4_ff;
   logic [rsb_pkg::SumW-1:0]   sum1_ff, sum_in;
   rsb_pkg::chan_type          gray2_ff;
   logic signed [rsb_pkg::VW-1:0] vr3_ff, vg3_ff, vb3_ff;
   logic [rsb_pkg::ColorW-1:0] out_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         boost_enable_ff <= 1'b0;
      end else if (csr_valid) begin
         boost_enable_ff <= csr_data;
      end
   end

   // a stage advances when it is empty or its content moves on
   assign adv4 = !v4_ff || rsp_tready;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_tready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_tvalid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
         if (adv4) v4_ff <= v3_ff;
      end
   end

   assign sum_in = rsb_pkg::SumW'(req_tdata[0 +: CW])
                 + rsb_pkg::SumW'(req_tdata[CW +: CW])
                 + rsb_pkg::SumW'(req_tdata[2*CW +: CW]);

   always_comb begin
      out_in = color3_ff;
      if (en3_ff) begin
         out_in = {1'b0,
                   rsb_pkg::clip(vb3_ff, color3_ff[2*CW +: CW]),
                   rsb_pkg::clip(vg3_ff, color3_ff[CW +: CW]),
                   rsb_pkg::clip(vr3_ff, color3_ff[0 +: CW])};
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         color1_ff <= req_tdata;
         en1_ff    <= boost_enable_ff;
         sum1_ff   <= sum_in;
      end
      if (adv2) begin
         color2_ff <= color1_ff;
         en2_ff    <= en1_ff;
         gray2_ff  <= rsb_pkg::gray_of(sum1_ff);
      end
      if (adv3) begin
         color3_ff <= color2_ff;
         en3_ff    <= en2_ff;
         vr3_ff    <= rsb_pkg::boost_v(color2_ff[0 +: CW], gray2_ff);
         vg3_ff    <= rsb_pkg::boost_v(color2_ff[CW +: CW], gray2_ff);
         vb3_ff    <= rsb_pkg::boost_v(color2_ff[2*CW +: CW], gray2_ff);
      end
      if (adv4) begin
         out_ff <= out_in;
         en4_ff <= en3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out_ff;

`ifndef ASSERT_OFF
   logic [rsb_pkg::SumW-1:0] chk_sum2;
   logic [rsb_pkg::SumW-1:0] chk_gray3;
   assign chk_sum2  = rsb_pkg::SumW'(color2_ff[0 +: CW])
                    + rsb_pkg::SumW'(color2_ff[CW +: CW])
                    + rsb_pkg::SumW'(color2_ff[2*CW +: CW]);
   assign chk_gray3 = rsb_pkg::SumW'(gray2_ff) * rsb_pkg::SumW'(3);

   // gray from the reciprocal must be the exact floor of sum/3
   a_gray_exact: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (chk_gray3 <= chk_sum2) && (chk_sum2 < chk_gray3 + 7'd3))
      else $error("gray estimate differs from sum/3");

   // boosted values stay inside the range the clip curve expects
   a_v_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (vr3_ff >= -8'sd41) && (vr3_ff <= 8'sd81)
             && (vg3_ff >= -8'sd41) && (vg3_ff <= 8'sd81)
             && (vb3_ff >= -8'sd41) && (vb3_ff <= 8'sd81))
      else $error("boosted channel out of range");

   // a stalled stage keeps its word
   a_hold_stage3: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !adv4 |=> v3_ff && $stable(color3_ff))
      else $error("stage 3 word lost during stall");

   // boosted words leave with the spare bit cleared
   a_spare_clear: assert property (@(posedge clock) disable iff (reset)
      v4_ff && en4_ff |-> !out_ff[15])
      else $error("spare bit set on boosted word");
`endif

endmodule
